>>> hw/rtl/gmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmm_pkg: shared types and constants for the grouped min/max/mean block
// Field widths, group record layout, back-end state encoding and the
// packing of the stream buses.
// ----------------------------------------------------------------------------
package gmm_pkg;

   // Field widths of the sample and result transactions.
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 12;
   localparam int TEMP_W  = 8;
   localparam int MEAN_W  = 15;

   // Accumulator widths. The record count field covers the largest
   // supported group size limit.
   localparam int SUM_W = 24;
   localparam int CNT_W = 24;

   // Mean scaling to hundredths and the divider that follows it.
   localparam int SCALE      = 100;
   localparam int SCALED_W   = 30;
   localparam int DIV_STEPS  = SCALED_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int MEAN_LIMIT = 128 * SCALE;

   // Stream bus widths, whole bytes.
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;

   // Defaults for the top-level parameters.
   localparam int MAX_GROUP_SAMPLES_DEFAULT = 65535;
   localparam int QUEUE_DEPTH_DEFAULT       = 4;

   // Reset values of the running extremes.
   localparam logic signed [TEMP_W-1:0] TEMP_LOW  = 8'sh80;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 8'sh7F;

   // Clamp limits of the running sum.
   localparam logic signed [SUM_W-1:0] SUM_HIGH = 24'sh7FFFFF;
   localparam logic signed [SUM_W-1:0] SUM_LOW  = 24'sh800000;

   // One closed group, as handed from the front end to the back end.
   typedef struct packed {
      logic [MONTH_W-1:0]        month;
      logic signed [TEMP_W-1:0]  t_min;
      logic signed [TEMP_W-1:0]  t_max;
      logic signed [SUM_W-1:0]   sum;
      logic [CNT_W-1:0]          count;
      logic [YEAR_W-1:0]         year;
      logic                      is_final;
   } gmm_rec_type;

   // Up to two group records written into the queue in one cycle.
   typedef struct packed {
      logic        close_valid;
      logic        final_valid;
      gmm_rec_type close_rec;
      gmm_rec_type final_rec;
   } gmm_push_type;

   // One result transaction.
   typedef struct packed {
      logic [MONTH_W-1:0]        group_month;
      logic signed [TEMP_W-1:0]  group_min;
      logic signed [TEMP_W-1:0]  group_max;
      logic signed [MEAN_W-1:0]  group_mean_centi;
      logic [YEAR_W-1:0]         series_year;
      logic                      final_result;
   } gmm_result_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCALE,
      BK_DIVIDE,
      BK_EMIT
   } gmm_back_state_type;

endpackage

>>> hw/rtl/gmm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmm_front: sample accumulator
// Takes one sample per cycle while the queue has room, tracks the open month
// group and hands the closed group and the final group to the queue as records.
// ----------------------------------------------------------------------------
module gmm_front #(
   parameter int MAX_GROUP_SAMPLES = gmm_pkg::MAX_GROUP_SAMPLES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   output logic                              item_ready,
   input  logic [gmm_pkg::MONTH_W-1:0]       month,
   input  logic [gmm_pkg::YEAR_W-1:0]        year,
   input  logic signed [gmm_pkg::TEMP_W-1:0] temp,
   input  logic                              last,
   input  logic                              room,
   output gmm_pkg::gmm_push_type             push
);

   localparam int CNT_BITS = $clog2(MAX_GROUP_SAMPLES + 1);

   // Open group state.
   logic                              open_ff, open_in;
   logic [gmm_pkg::MONTH_W-1:0]       month_ff, month_in;
   logic signed [gmm_pkg::TEMP_W-1:0] min_ff, min_in;
   logic signed [gmm_pkg::TEMP_W-1:0] max_ff, max_in;
   logic signed [gmm_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_BITS-1:0]               count_ff, count_in;

   logic                              accept;
   logic                              close;
   logic signed [gmm_pkg::TEMP_W-1:0] base_min, base_max, new_min, new_max;
   logic signed [gmm_pkg::SUM_W-1:0]  base_sum, new_sum;
   logic signed [gmm_pkg::SUM_W:0]    sum_wide;
   logic [CNT_BITS-1:0]               base_count, new_count;

   // A sample is taken only when the queue can absorb two records.
   assign item_ready = room;
   assign accept     = item_valid && room;

   // A month change closes the open group before this sample counts.
   assign close = open_ff && (month != month_ff);

   always_comb begin
      base_min   = close ? gmm_pkg::TEMP_HIGH : min_ff;
      base_max   = close ? gmm_pkg::TEMP_LOW  : max_ff;
      base_sum   = close ? '0 : sum_ff;
      base_count = close ? '0 : count_ff;

      new_min = (temp < base_min) ? temp : base_min;
      new_max = (temp > base_max) ? temp : base_max;

      // Saturating add, clamped to the signed sum range.
      sum_wide = (gmm_pkg::SUM_W+1)'(base_sum) + (gmm_pkg::SUM_W+1)'(temp);
      if (sum_wide[gmm_pkg::SUM_W] != sum_wide[gmm_pkg::SUM_W-1]) begin
         new_sum = sum_wide[gmm_pkg::SUM_W] ? gmm_pkg::SUM_LOW : gmm_pkg::SUM_HIGH;
      end else begin
         new_sum = sum_wide[gmm_pkg::SUM_W-1:0];
      end

      // Once the count reaches its limit, sum and count hold.
      if (base_count < CNT_BITS'(MAX_GROUP_SAMPLES)) begin
         new_count = base_count + 1'b1;
      end else begin
         new_sum   = base_sum;
         new_count = base_count;
      end
   end

   // Records for the queue: the closed group first, then the final one.
   always_comb begin
      push.close_valid        = accept && close;
      push.final_valid        = accept && last;
      push.close_rec.month    = month_ff;
      push.close_rec.t_min    = min_ff;
      push.close_rec.t_max    = max_ff;
      push.close_rec.sum      = sum_ff;
      push.close_rec.count    = gmm_pkg::CNT_W'(count_ff);
      push.close_rec.year     = '0;
      push.close_rec.is_final = 1'b0;
      push.final_rec.month    = month;
      push.final_rec.t_min    = new_min;
      push.final_rec.t_max    = new_max;
      push.final_rec.sum      = new_sum;
      push.final_rec.count    = gmm_pkg::CNT_W'(new_count);
      push.final_rec.year     = year;
      push.final_rec.is_final = 1'b1;
   end

   // Next group state: a last sample ends the series and clears everything.
   always_comb begin
      open_in  = open_ff;
      month_in = month_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            open_in  = 1'b0;
            month_in = '0;
            min_in   = gmm_pkg::TEMP_HIGH;
            max_in   = gmm_pkg::TEMP_LOW;
            sum_in   = '0;
            count_in = '0;
         end else begin
            open_in  = 1'b1;
            month_in = month;
            min_in   = new_min;
            max_in   = new_max;
            sum_in   = new_sum;
            count_in = new_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         month_ff <= '0;
         min_ff   <= gmm_pkg::TEMP_HIGH;
         max_ff   <= gmm_pkg::TEMP_LOW;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         open_ff  <= open_in;
         month_ff <= month_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/gmm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmm_queue: group record queue
// Short queue between accumulator and divider. Takes up to two records a
// cycle and gives one record a cycle from its head.
// ----------------------------------------------------------------------------
module gmm_queue #(
   parameter int QUEUE_DEPTH = gmm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gmm_pkg::gmm_push_type push,
   output logic                  room,
   output logic                  head_valid,
   output gmm_pkg::gmm_rec_type  head,
   input  logic                  pop
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   gmm_pkg::gmm_rec_type entry_ff [QUEUE_DEPTH];

   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  wr_next;
   logic [PTR_W-1:0]  final_ptr;
   logic              pop_ok;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      wrap_inc = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign room       = fill_ff <= FILL_W'(QUEUE_DEPTH - 2);
   assign head_valid = fill_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign pop_ok     = pop && head_valid;

   // The final record goes behind the closed one when both arrive together.
   assign wr_next   = wrap_inc(wr_ptr_ff);
   assign final_ptr = push.close_valid ? wr_next : wr_ptr_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.close_valid && push.final_valid) begin
         wr_ptr_in = wrap_inc(wr_next);
      end else if (push.close_valid || push.final_valid) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = pop_ok ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(push.close_valid) + FILL_W'(push.final_valid)
                  - FILL_W'(pop_ok);
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (push.close_valid) begin
         entry_ff[wr_ptr_ff] <= push.close_rec;
      end
      if (push.final_valid) begin
         entry_ff[final_ptr] <= push.final_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> hw/rtl/gmm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmm_back: mean divider and result register
// Pops one group record, scales the sum to hundredths, divides it by the
// count one quotient bit per cycle and loads the result register.
// ----------------------------------------------------------------------------
module gmm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  gmm_pkg::gmm_rec_type    head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output gmm_pkg::gmm_result_type rsp_data
);

   gmm_pkg::gmm_back_state_type state_ff, state_in;

   gmm_pkg::gmm_rec_type          rec_ff;
   logic [gmm_pkg::SCALED_W-1:0]  quo_ff;
   logic [gmm_pkg::CNT_W-1:0]     rem_ff;
   logic [gmm_pkg::STEP_W-1:0]    step_ff;
   logic                          neg_ff;
   logic                          out_valid_ff;
   gmm_pkg::gmm_result_type       out_ff;

   logic                          out_load;
   logic                          div_done;
   logic [gmm_pkg::SUM_W-1:0]     abs_sum;
   logic [gmm_pkg::CNT_W:0]       rem_shift;
   logic                          fits;
   logic [gmm_pkg::CNT_W:0]       rem_next;
   logic [gmm_pkg::MEAN_W-1:0]    quo_low;
   logic [gmm_pkg::MEAN_W-1:0]    mean;

   assign div_done = step_ff == gmm_pkg::STEP_W'(gmm_pkg::DIV_STEPS - 1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gmm_pkg::BK_IDLE: begin
            if (head_valid) state_in = gmm_pkg::BK_SCALE;
         end
         gmm_pkg::BK_SCALE: begin
            state_in = gmm_pkg::BK_DIVIDE;
         end
         gmm_pkg::BK_DIVIDE: begin
            if (div_done) state_in = gmm_pkg::BK_EMIT;
         end
         gmm_pkg::BK_EMIT: begin
            if (out_load) state_in = gmm_pkg::BK_IDLE;
         end
         default: begin
            state_in = gmm_pkg::BK_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      pop      = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         gmm_pkg::BK_IDLE: begin
            pop = head_valid;
         end
         gmm_pkg::BK_EMIT: begin
            out_load = !out_valid_ff || rsp_ready;
         end
         default: begin
            pop      = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   // Restoring division step: magnitude of sum*100 over the count.
   always_comb begin
      abs_sum   = rec_ff.sum[gmm_pkg::SUM_W-1] ? (~rec_ff.sum + 1'b1) : rec_ff.sum;
      rem_shift = {rem_ff, quo_ff[gmm_pkg::SCALED_W-1]};
      fits      = rem_shift >= {1'b0, rec_ff.count};
      rem_next  = fits ? (rem_shift - {1'b0, rec_ff.count}) : rem_shift;
      quo_low   = quo_ff[gmm_pkg::MEAN_W-1:0];
      if (rec_ff.count == '0) begin
         mean = '0;
      end else if (neg_ff) begin
         mean = ~quo_low + 1'b1;
      end else begin
         mean = quo_low;
      end
   end

   // Divider datapath.
   always_ff @(posedge clock) begin
      if (pop) begin
         rec_ff <= head;
      end
      if (state_ff == gmm_pkg::BK_SCALE) begin
         neg_ff  <= rec_ff.sum[gmm_pkg::SUM_W-1];
         quo_ff  <= gmm_pkg::SCALED_W'(abs_sum) * gmm_pkg::SCALED_W'(gmm_pkg::SCALE);
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (state_ff == gmm_pkg::BK_DIVIDE) begin
         quo_ff  <= {quo_ff[gmm_pkg::SCALED_W-2:0], fits};
         rem_ff  <= rem_next[gmm_pkg::CNT_W-1:0];
         step_ff <= step_ff + 1'b1;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff.group_month      <= rec_ff.month;
         out_ff.group_min        <= rec_ff.t_min;
         out_ff.group_max        <= rec_ff.t_max;
         out_ff.group_mean_centi <= mean;
         out_ff.series_year      <= rec_ff.year;
         out_ff.final_result     <= rec_ff.is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gmm_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // A new result only appears when the sequencer finishes a division.
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == gmm_pkg::BK_EMIT)
      else $error("result register loaded outside the emit state");

   // Scaling always follows a pop from the queue.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == gmm_pkg::BK_SCALE |-> $past(pop))
      else $error("scale step entered without a popped record");

   // The mean magnitude never exceeds 128 degrees in hundredths.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmm_pkg::BK_EMIT && rec_ff.count != '0)
      |-> quo_ff <= gmm_pkg::SCALED_W'(gmm_pkg::MEAN_LIMIT))
      else $error("division quotient out of range");

   // The divider stays in the divide state until the last quotient bit is formed.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == gmm_pkg::BK_DIVIDE && !div_done |=> state_ff == gmm_pkg::BK_DIVIDE)
      else $error("division left before all quotient bits were formed");

endmodule

>>> hw/rtl/grouped_min_max_mean.sv
`timescale 1ns / 1ps
// Samples are taken one per cycle while the record queue has two free slots.
// Each reported group passes through the back end in order: a pop, the scale
// step, the bit-serial divider (one quotient bit per cycle) and the load of the
// result register. Synchronous active-high reset clears the open group, the
// queue and the result valid flag; the block is ready as soon as reset drops.
// ----------------------------------------------------------------------------
// grouped_min_max_mean: per-month running min, max and mean
// Groups consecutive samples with the same month and reports each closed
// group and the final group of a series with its min, max and mean.
// ----------------------------------------------------------------------------
module grouped_min_max_mean #(
   parameter int MAX_GROUP_SAMPLES = gmm_pkg::MAX_GROUP_SAMPLES_DEFAULT,
   parameter int QUEUE_DEPTH       = gmm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Sample transactions.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [3:0] month_number, [15:4] year_number, [23:16] temperature
   input  logic [gmm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   // Result transactions.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] group_month, [11:4] group_min, [19:12] group_max,
   // [34:20] group_mean_centi, [46:35] series_year, [47] zero
   output logic [gmm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   gmm_pkg::gmm_push_type   push;
   gmm_pkg::gmm_rec_type    head;
   gmm_pkg::gmm_result_type result;
   logic                    room;
   logic                    head_valid;
   logic                    pop;

   // Sample unpacking.
   logic [gmm_pkg::MONTH_W-1:0]       month_number;
   logic [gmm_pkg::YEAR_W-1:0]        year_number;
   logic signed [gmm_pkg::TEMP_W-1:0] temperature;

   assign month_number = req_tdata[3:0];
   assign year_number  = req_tdata[15:4];
   assign temperature  = req_tdata[23:16];

   gmm_front #(
      .MAX_GROUP_SAMPLES(MAX_GROUP_SAMPLES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .item_valid(req_tvalid),
      .item_ready(req_tready),
      .month     (month_number),
      .year      (year_number),
      .temp      (temperature),
      .last      (req_tlast),
      .room      (room),
      .push      (push)
   );

   gmm_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .head_valid(head_valid),
      .head      (head),
      .pop       (pop)
   );

   gmm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (result)
   );

   // Result packing.
   assign rsp_tdata = {1'b0, result.series_year, result.group_mean_centi,
                       result.group_max, result.group_min, result.group_month};
   assign rsp_tlast = result.final_result;

endmodule
